>>> src/cslw_pkg.sv
// ----------------------------------------------------------------------------
// cslw_pkg
// Shared types and constants of the command slew limiter with watchdog.
// ----------------------------------------------------------------------------
package cslw_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned LIMIT_W  = 31;
    localparam int unsigned AGE_W    = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned CFG_W    = 32;

    // pi/180 in unsigned Q0.32, rounded to nearest.
    localparam int unsigned DEG2RAD_W   = 27;
    localparam logic [DEG2RAD_W-1:0] DEG2RAD_Q32 = 27'd74961321;

    localparam logic [AGE_W-1:0] AGE_MAX     = 16'hFFFF;
    localparam logic [AGE_W-1:0] TIMEOUT_CAP = 16'hFFFE;

    typedef enum logic [MODE_W-1:0] {
        MODE_STEER = 2'd0,
        MODE_SPEED = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_STEER_LIMIT   = 3'd0,
        REG_STEER_STEP    = 3'd1,
        REG_SPEED_LIMIT   = 3'd2,
        REG_ACCEL_STEP    = 3'd3,
        REG_DECEL_STEP    = 3'd4,
        REG_TIMEOUT_TICKS = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] steer_limit;
        logic [LIMIT_W-1:0] steer_step;
        logic [LIMIT_W-1:0] speed_limit;
        logic [LIMIT_W-1:0] accel_step;
        logic [LIMIT_W-1:0] decel_step;
        logic [AGE_W-1:0]   timeout_ticks;
    } cfg_regs_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] steer_command;
        logic signed [VALUE_W-1:0] speed_command;
        logic [AGE_W-1:0]          steer_age;
        logic [AGE_W-1:0]          speed_age;
        logic signed [VALUE_W-1:0] steer_output;
        logic [LIMIT_W-1:0]        speed_output;
        logic                      stale;
    } cslw_state_t;

    localparam cfg_regs_t CFG_RESET = '{
        steer_limit:   31'd1310720,
        steer_step:    31'd786432,
        speed_limit:   31'd39322,
        accel_step:    31'd1966,
        decel_step:    31'd1966,
        timeout_ticks: 16'd15
    };

    localparam cslw_state_t STATE_RESET = '{
        steer_command: 32'sd0,
        speed_command: 32'sd0,
        steer_age:     AGE_MAX,
        speed_age:     AGE_MAX,
        steer_output:  32'sd0,
        speed_output:  31'd0,
        stale:         1'b0
    };

endpackage

>>> src/cslw_if.sv
// ----------------------------------------------------------------------------
// cslw_if
// Handshake channels of the slew limiter: input items, results and
// register writes.
// ----------------------------------------------------------------------------
interface cslw_item_if
    import cslw_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] command_value;
    logic                      value_invalid;

    modport source (output valid, output mode, output command_value,
                    output value_invalid, input ready);
    modport sink   (input valid, input mode, input command_value,
                    input value_invalid, output ready);
endinterface

interface cslw_result_if
    import cslw_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] steer_rad;
    logic [LIMIT_W-1:0]        speed_out;
    logic                      timed_out;

    modport source (output valid, output steer_rad, output speed_out,
                    output timed_out, input ready);
    modport sink   (input valid, input steer_rad, input speed_out,
                    input timed_out, output ready);
endinterface

interface cslw_cfg_if
    import cslw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [CFG_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/cslw_update.sv
// ----------------------------------------------------------------------------
// cslw_update
// Next-state logic for one item: command capture, watchdog ageing, target
// clamping and per-tick slew limiting of both outputs.
// ----------------------------------------------------------------------------
module cslw_update
    import cslw_pkg::*;
(
    input  cfg_regs_t                 cfg_regs,
    input  cslw_state_t               state,
    input  logic [MODE_W-1:0]         mode,
    input  logic signed [VALUE_W-1:0] command_value,
    input  logic                      value_invalid,
    output cslw_state_t               state_next
);

    logic signed [VALUE_W-1:0] value;
    logic [AGE_W-1:0]          steer_age_up;
    logic [AGE_W-1:0]          speed_age_up;
    logic [AGE_W-1:0]          age_limit;
    logic                      fresh;

    logic signed [VALUE_W:0]   steer_cmd_ext;
    logic signed [VALUE_W:0]   steer_lim_pos;
    logic signed [VALUE_W:0]   steer_lim_neg;
    logic signed [VALUE_W:0]   steer_clamped;
    logic signed [VALUE_W:0]   steer_target;
    logic signed [VALUE_W:0]   steer_cur;
    logic signed [VALUE_W:0]   steer_diff;
    logic [VALUE_W:0]          steer_mag;
    logic [VALUE_W:0]          steer_step_ext;
    logic signed [VALUE_W:0]   steer_moved;

    logic [LIMIT_W-1:0]        speed_clamped;
    logic [LIMIT_W-1:0]        speed_target;
    logic signed [LIMIT_W:0]   speed_diff;
    logic [LIMIT_W:0]          speed_mag;
    logic [LIMIT_W-1:0]        speed_step;
    logic [LIMIT_W-1:0]        speed_moved;

    assign value = value_invalid ? '0 : command_value;

    assign steer_age_up = (state.steer_age == AGE_MAX) ? AGE_MAX : state.steer_age + 1'b1;
    assign speed_age_up = (state.speed_age == AGE_MAX) ? AGE_MAX : state.speed_age + 1'b1;
    assign age_limit    = (cfg_regs.timeout_ticks > TIMEOUT_CAP) ? TIMEOUT_CAP
                                                                 : cfg_regs.timeout_ticks;
    assign fresh        = (steer_age_up <= age_limit) && (speed_age_up <= age_limit);

    // Steering target, clamped to plus or minus the limit.
    assign steer_cmd_ext = {state.steer_command[VALUE_W-1], state.steer_command};
    assign steer_lim_pos = $signed({2'b00, cfg_regs.steer_limit});
    assign steer_lim_neg = -steer_lim_pos;

    always_comb
    begin
        priority if (steer_cmd_ext > steer_lim_pos)
        begin
            steer_clamped = steer_lim_pos;
        end
        else if (steer_cmd_ext < steer_lim_neg)
        begin
            steer_clamped = steer_lim_neg;
        end
        else
        begin
            steer_clamped = steer_cmd_ext;
        end
    end

    assign steer_target   = fresh ? steer_clamped : '0;
    assign steer_cur      = {state.steer_output[VALUE_W-1], state.steer_output};
    assign steer_diff     = steer_target - steer_cur;
    assign steer_mag      = steer_diff[VALUE_W] ? (VALUE_W+1)'(0) - steer_diff : steer_diff;
    assign steer_step_ext = {2'b00, cfg_regs.steer_step};

    always_comb
    begin
        priority if (steer_mag <= steer_step_ext)
        begin
            steer_moved = steer_target;
        end
        else if (steer_diff[VALUE_W])
        begin
            steer_moved = steer_cur - $signed(steer_step_ext);
        end
        else
        begin
            steer_moved = steer_cur + $signed(steer_step_ext);
        end
    end

    // Speed target, clamped to zero and the maximum speed.
    always_comb
    begin
        priority if (state.speed_command[VALUE_W-1])
        begin
            speed_clamped = '0;
        end
        else if (state.speed_command[LIMIT_W-1:0] > cfg_regs.speed_limit)
        begin
            speed_clamped = cfg_regs.speed_limit;
        end
        else
        begin
            speed_clamped = state.speed_command[LIMIT_W-1:0];
        end
    end

    assign speed_target = fresh ? speed_clamped : '0;
    assign speed_diff   = $signed({1'b0, speed_target}) - $signed({1'b0, state.speed_output});
    assign speed_mag    = speed_diff[LIMIT_W] ? (LIMIT_W+1)'(0) - speed_diff : speed_diff;
    assign speed_step   = speed_diff[LIMIT_W] ? cfg_regs.decel_step : cfg_regs.accel_step;

    always_comb
    begin
        priority if (speed_mag <= {1'b0, speed_step})
        begin
            speed_moved = speed_target;
        end
        else if (speed_diff[LIMIT_W])
        begin
            speed_moved = state.speed_output - speed_step;
        end
        else
        begin
            speed_moved = state.speed_output + speed_step;
        end
    end

    always_comb
    begin
        state_next = state;
        unique case (mode)
            MODE_STEER:
            begin
                state_next.steer_command = value;
                state_next.steer_age     = '0;
            end
            MODE_SPEED:
            begin
                state_next.speed_command = value;
                state_next.speed_age     = '0;
            end
            MODE_TICK:
            begin
                state_next.steer_age    = steer_age_up;
                state_next.speed_age    = speed_age_up;
                state_next.stale        = !fresh;
                state_next.steer_output = steer_moved[VALUE_W-1:0];
                state_next.speed_output = speed_moved;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

>>> src/command_slew_limiter_watchdog_core.sv
// ----------------------------------------------------------------------------
// command_slew_limiter_watchdog_core
// Steering and speed command slew limiter with a command freshness watchdog.
//
//   Channel  Role    Transfers
//   item     sink    mode, command_value, value_invalid
//   result   source  steer_rad, speed_out, timed_out (one per tick)
//   cfg      sink    index, data (always ready)
//
// One item is taken per cycle unless a tick in the input register waits for
// room downstream. A tick passes the input register, then the state update,
// then the result register; the degrees-to-radians multiply sits before it.
// Reset loads the register defaults and marks both commands stale.
// A stalled result holds the pipeline; commands still drain behind it.
// ----------------------------------------------------------------------------
module command_slew_limiter_watchdog_core
    import cslw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cslw_item_if.sink    item,
    cslw_result_if.source result,
    cslw_cfg_if.sink     cfg
);

    localparam int unsigned PROD_W = VALUE_W + DEG2RAD_W + 1;

    cfg_regs_t                 cfg_reg;
    cslw_state_t               state_reg;
    cslw_state_t               state_next;

    logic                      a_valid_reg;
    logic [MODE_W-1:0]         a_mode_reg;
    logic signed [VALUE_W-1:0] a_value_reg;
    logic                      a_invalid_reg;

    logic                      b_valid_reg;

    logic                      c_valid_reg;
    logic signed [VALUE_W-1:0] c_steer_reg;
    logic [LIMIT_W-1:0]        c_speed_reg;
    logic                      c_stale_reg;

    logic                      c_free;
    logic                      b_free;
    logic                      a_adv;
    logic                      a_is_tick;

    logic signed [PROD_W-1:0]  rad_prod;
    logic signed [PROD_W-1:0]  rad_sum;

    // Register writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STEER_LIMIT:   cfg_reg.steer_limit   <= cfg.data[LIMIT_W-1:0];
                REG_STEER_STEP:    cfg_reg.steer_step    <= cfg.data[LIMIT_W-1:0];
                REG_SPEED_LIMIT:   cfg_reg.speed_limit   <= cfg.data[LIMIT_W-1:0];
                REG_ACCEL_STEP:    cfg_reg.accel_step    <= cfg.data[LIMIT_W-1:0];
                REG_DECEL_STEP:    cfg_reg.decel_step    <= cfg.data[LIMIT_W-1:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg.data[AGE_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Pipeline flow. Only ticks need room downstream.
    assign c_free     = !c_valid_reg || result.ready;
    assign b_free     = !b_valid_reg || c_free;
    assign a_is_tick  = (a_mode_reg == MODE_TICK);
    assign a_adv      = a_valid_reg && (!a_is_tick || b_free);
    assign item.ready = !a_valid_reg || a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            a_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            a_mode_reg    <= item.mode;
            a_value_reg   <= item.command_value;
            a_invalid_reg <= item.value_invalid;
        end
    end

    cslw_update u_update (
        .cfg_regs      (cfg_reg),
        .state         (state_reg),
        .mode          (a_mode_reg),
        .command_value (a_value_reg),
        .value_invalid (a_invalid_reg),
        .state_next    (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (a_adv)
        begin
            state_reg <= state_next;
        end
    end

    // While a tick waits in stage B, no other tick can pass, so the output
    // and stale fields of the state register still belong to that tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_free)
        begin
            b_valid_reg <= a_adv && a_is_tick;
        end
    end

    // Degrees to radians, rounded to nearest with ties upwards.
    assign rad_prod = state_reg.steer_output * $signed({1'b0, DEG2RAD_Q32});
    assign rad_sum  = rad_prod + $signed(PROD_W'(64'h8000_0000));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_free)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && c_free)
        begin
            c_steer_reg <= VALUE_W'(rad_sum >>> VALUE_W);
            c_speed_reg <= state_reg.speed_output;
            c_stale_reg <= state_reg.stale;
        end
    end

    assign result.valid     = c_valid_reg;
    assign result.steer_rad = c_steer_reg;
    assign result.speed_out = c_speed_reg;
    assign result.timed_out = c_stale_reg;

endmodule

>>> src/cslw_checker.sv
// ----------------------------------------------------------------------------
// cslw_checker
// Port-level checks on the slew limiter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cslw_checker
    import cslw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_ready,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [VALUE_W-1:0] steer_rad,
    input  logic [LIMIT_W-1:0]        speed_out,
    input  logic                      timed_out
);

    logic               prev_valid_reg;
    logic               prev_stale_reg;
    logic [LIMIT_W-1:0] prev_speed_reg;
    logic               out_accept;

    assign out_accept = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_stale_reg <= 1'b0;
            prev_speed_reg <= '0;
        end
        else if (out_accept)
        begin
            prev_valid_reg <= 1'b1;
            prev_stale_reg <= timed_out;
            prev_speed_reg <= speed_out;
        end
    end

    // The input side only stalls when a finished result is waiting.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // With stale commands the speed target is zero, so speed cannot rise.
    a_stale_speed_falls: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && timed_out && prev_valid_reg && prev_stale_reg)
            |-> (speed_out <= prev_speed_reg))
        else $error("speed rose while commands were stale");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before transaction");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            ($stable(steer_rad) && $stable(speed_out) && $stable(timed_out)))
        else $error("result payload changed while stalled");

endmodule

bind command_slew_limiter_watchdog_core cslw_checker u_cslw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .steer_rad (result.steer_rad),
    .speed_out (result.speed_out),
    .timed_out (result.timed_out)
);
